>>> rtl/core/ebbe_pkg.sv
`default_nettype none

package ebbe_pkg;

    localparam int unsigned SIZE_W    = 17;
    localparam int unsigned INDEX_W   = 16;
    localparam int unsigned VALUE_W   = 24;
    localparam int unsigned VBYTES_W  = 2;
    localparam int unsigned APB_AW    = 3;
    localparam int unsigned APB_DW    = 32;

    localparam logic [VALUE_W-1:0]  MARKER_VALUE     = 24'hFFFFFF;
    localparam logic [7:0]          ERASED_BYTE      = 8'hFF;
    localparam logic [SIZE_W-1:0]   BLOCK_SIZE_RESET = 17'd4096;
    localparam logic [APB_AW-1:0]   ADDR_BLOCK_SIZE  = 3'd0;
    localparam int unsigned         QUEUE_DEPTH      = 4;

    localparam logic [VBYTES_W-1:0] VB_SMALL  = 2'd1;
    localparam logic [VBYTES_W-1:0] VB_LARGE  = 2'd2;
    localparam logic [VBYTES_W-1:0] VB_MARKER = 2'd3;

    // what one accepted byte produced
    typedef enum logic [1:0] {
        K_SMALL,
        K_LARGE,
        K_MARKER,
        K_MARKER_LARGE
    } t_kind;

    typedef struct packed {
        t_kind              kind;
        logic [INDEX_W-1:0] index;
    } t_rec;

endpackage

`default_nettype wire

>>> rtl/core/ebbe_front.sv
`default_nettype none

module ebbe_front (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire [ebbe_pkg::SIZE_W-1:0]    i_block_size,
    input  wire                           i_accept,
    input  wire [7:0]                     i_data_byte,
    input  wire                           i_last_byte,
    output logic                          o_rec_valid,
    output ebbe_pkg::t_rec                o_rec
);
    import ebbe_pkg::*;

    logic [SIZE_W-1:0]  r_bytes,   n_bytes;
    logic [INDEX_W-1:0] r_index,   n_index;
    logic               r_all_ff,  n_all_ff;
    logic               r_any,     n_any;
    logic               r_marker,  n_marker;

    logic [SIZE_W:0]    w_count;
    logic               w_all_ff;
    logic               w_close;
    logic               w_found;
    logic               w_small;

    always_comb begin
        w_all_ff = r_all_ff & (i_data_byte == ERASED_BYTE);
        w_count  = {1'b0, r_bytes} + {{SIZE_W{1'b0}}, 1'b1};
        w_close  = (w_count >= {1'b0, i_block_size}) | i_last_byte;
        w_found  = w_close & w_all_ff;
        w_small  = (r_index[INDEX_W-1:8] == '0);

        o_rec_valid = w_found | (i_last_byte & ~r_any);
        o_rec.index = r_index;
        if (w_found) begin
            if (w_small) begin
                o_rec.kind = K_SMALL;
            end else if (r_marker) begin
                o_rec.kind = K_LARGE;
            end else begin
                o_rec.kind = K_MARKER_LARGE;
            end
        end else begin
            o_rec.kind = K_MARKER;
        end

        n_bytes  = r_bytes;
        n_index  = r_index;
        n_all_ff = r_all_ff;
        n_any    = r_any;
        n_marker = r_marker;
        if (i_accept) begin
            if (i_last_byte) begin
                n_bytes  = '0;
                n_index  = '0;
                n_all_ff = 1'b1;
                n_any    = 1'b0;
                n_marker = 1'b0;
            end else if (w_close) begin
                n_bytes  = '0;
                n_index  = r_index + INDEX_W'(1);
                n_all_ff = 1'b1;
                n_any    = r_any | w_found;
                n_marker = r_marker | (w_found & ~w_small);
            end else begin
                n_bytes  = w_count[SIZE_W-1:0];
                n_all_ff = w_all_ff;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bytes  <= '0;
            r_index  <= '0;
            r_all_ff <= 1'b1;
            r_any    <= 1'b0;
            r_marker <= 1'b0;
        end else begin
            r_bytes  <= n_bytes;
            r_index  <= n_index;
            r_all_ff <= n_all_ff;
            r_any    <= n_any;
            r_marker <= n_marker;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/ebbe_queue.sv
`default_nettype none

module ebbe_queue #(
    parameter int unsigned DEPTH = ebbe_pkg::QUEUE_DEPTH
) (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_wr,
    input  ebbe_pkg::t_rec  i_wr_rec,
    input  wire             i_rd,
    output logic            o_full,
    output logic            o_empty,
    output ebbe_pkg::t_rec  o_head
);
    import ebbe_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    t_rec               r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0]   r_count,  n_count;
    logic               w_wr;
    logic               w_rd;

    always_comb begin
        o_full  = (r_count == CNT_W'(DEPTH));
        o_empty = (r_count == '0);
        o_head  = r_mem[r_rd_ptr];
        w_wr    = i_wr & ~o_full;
        w_rd    = i_rd & ~o_empty;

        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_wr) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (w_rd) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        if (w_wr && !w_rd) begin
            n_count = r_count + CNT_W'(1);
        end else if (w_rd && !w_wr) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr_ptr] <= i_wr_rec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("queue count above depth");

    a_no_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_wr && !o_full && !w_rd) |=> (r_count == $past(r_count) + CNT_W'(1)))
        else $error("queue write lost");

    a_hold_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && !i_rd) |=> (o_head == $past(o_head)))
        else $error("queue head changed without a read");
`endif

endmodule

`default_nettype wire

>>> rtl/core/ebbe_back.sv
`default_nettype none

module ebbe_back (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_q_empty,
    input  ebbe_pkg::t_rec                   i_q_head,
    output logic                             o_q_rd,
    output logic                             o_empty,
    input  wire                              i_pop,
    output logic [ebbe_pkg::VALUE_W-1:0]     o_encoded_value,
    output logic [ebbe_pkg::VBYTES_W-1:0]    o_value_bytes,
    output logic                             o_last_of_run
);
    import ebbe_pkg::*;

    // set while the marker of a marker-plus-index pair is already out
    logic r_second, n_second;
    logic w_pair;
    logic w_beat;

    always_comb begin
        w_pair  = (i_q_head.kind == K_MARKER_LARGE);
        o_empty = i_q_empty;
        w_beat  = i_pop & ~i_q_empty;

        o_last_of_run = ~(w_pair & ~r_second);
        case (i_q_head.kind)
            K_SMALL: begin
                o_encoded_value = {8'h00, i_q_head.index};
                o_value_bytes   = VB_SMALL;
            end
            K_LARGE: begin
                o_encoded_value = {8'h00, i_q_head.index};
                o_value_bytes   = VB_LARGE;
            end
            K_MARKER: begin
                o_encoded_value = MARKER_VALUE;
                o_value_bytes   = VB_MARKER;
            end
            default: begin
                o_encoded_value = r_second ? {8'h00, i_q_head.index} : MARKER_VALUE;
                o_value_bytes   = r_second ? VB_LARGE : VB_MARKER;
            end
        endcase

        o_q_rd   = w_beat & o_last_of_run;
        n_second = r_second;
        if (w_beat) begin
            n_second = w_pair & ~r_second;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_second <= 1'b0;
        end else begin
            r_second <= n_second;
        end
    end

`ifndef NO_ASSERTIONS
    a_second_on_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_second |-> (!i_q_empty && w_pair))
        else $error("second half without a pending pair");
`endif

endmodule

`default_nettype wire

>>> rtl/core/erased_block_bitmap_encoder_top.sv
// a byte's result is registered in the queue, whose head drives the result ports
// throughput: one byte per cycle while full is low; results leave at one per pop, and a
// byte that causes the marker plus a large index needs two pop beats, so the 4-entry
// result queue sets how long bursts of such bytes run before full rises
// reset: synchronous active-low i_rst_n clears the scan state and the queue and sets
// block_size to 4096; there is no clearing pass
`default_nettype none

module erased_block_bitmap_encoder_top #(
    parameter int unsigned QUEUE_DEPTH = ebbe_pkg::QUEUE_DEPTH
) (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    // config port
    input  wire                               psel,
    input  wire                               penable,
    input  wire                               pwrite,
    input  wire [ebbe_pkg::APB_AW-1:0]        paddr,
    input  wire [ebbe_pkg::APB_DW-1:0]        pwdata,
    output logic [ebbe_pkg::APB_DW-1:0]       prdata,
    output logic                              pready,
    // byte input
    input  wire                               push,
    output logic                              full,
    input  wire [7:0]                         i_data_byte,
    input  wire                               i_last_byte,
    // result output
    output logic                              empty,
    input  wire                               pop,
    output logic [ebbe_pkg::VALUE_W-1:0]      o_encoded_value,
    output logic [ebbe_pkg::VBYTES_W-1:0]     o_value_bytes,
    output logic                              o_last_of_run
);
    import ebbe_pkg::*;

    // block size register, written through the apb access phase
    logic [SIZE_W-1:0] r_block_size;
    logic              w_cfg_wr;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel & penable & pwrite & pready & (paddr == ADDR_BLOCK_SIZE);

    always_comb begin
        prdata = '0;
        if (paddr == ADDR_BLOCK_SIZE) begin
            prdata = {{(APB_DW - SIZE_W){1'b0}}, r_block_size};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_size <= BLOCK_SIZE_RESET;
        end else if (w_cfg_wr) begin
            r_block_size <= pwdata[SIZE_W-1:0];
        end
    end

    // front: counts bytes into blocks and classifies each accepted beat
    logic  w_accept;
    logic  w_rec_valid;
    t_rec  w_rec;
    logic  w_q_full;
    logic  w_q_empty;
    t_rec  w_q_head;
    logic  w_q_rd;

    // the queue always has room when full is low, so every accepted record lands
    assign full     = w_q_full;
    assign w_accept = push & ~w_q_full;

    ebbe_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_block_size (r_block_size),
        .i_accept     (w_accept),
        .i_data_byte  (i_data_byte),
        .i_last_byte  (i_last_byte),
        .o_rec_valid  (w_rec_valid),
        .o_rec        (w_rec)
    );

    // short queue between the byte scanner and the result serializer
    ebbe_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_wr     (w_accept & w_rec_valid),
        .i_wr_rec (w_rec),
        .i_rd     (w_q_rd),
        .o_full   (w_q_full),
        .o_empty  (w_q_empty),
        .o_head   (w_q_head)
    );

    // back: splits a marker-plus-index record into two result beats
    ebbe_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_q_empty       (w_q_empty),
        .i_q_head        (w_q_head),
        .o_q_rd          (w_q_rd),
        .o_empty         (empty),
        .i_pop           (pop),
        .o_encoded_value (o_encoded_value),
        .o_value_bytes   (o_value_bytes),
        .o_last_of_run   (o_last_of_run)
    );

endmodule

`default_nettype wire

>>> tb/tb_erased_block_bitmap_encoder_top.sv
`timescale 1ns / 1ps

module tb_erased_block_bitmap_encoder_top;
    import ebbe_pkg::*;

    localparam int CLK_HALF      = 4;
    localparam int RESET_CYCLES  = 8;
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int SETTLE_CYCLES = 8;
    localparam int MAX_PRINTED   = 100;

    localparam logic [INDEX_W-1:0] SMALL_INDEX_LIMIT = 16'h0100;

    // one expected result beat
    typedef struct packed {
        logic [VALUE_W-1:0]  value;
        logic [VBYTES_W-1:0] nbytes;
        logic                last;
    } t_erased_hit;

    logic                i_clk;
    logic                i_rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [APB_AW-1:0]   paddr;
    logic [APB_DW-1:0]   pwdata;
    logic [APB_DW-1:0]   prdata;
    logic                pready;
    logic                push;
    logic                full;
    logic [7:0]          i_data_byte;
    logic                i_last_byte;
    logic                empty;
    logic                pop;
    logic [VALUE_W-1:0]  o_encoded_value;
    logic [VBYTES_W-1:0] o_value_bytes;
    logic                o_last_of_run;

    // scan state mirrored by the predictor
    logic [SIZE_W-1:0]  scan_size        = BLOCK_SIZE_RESET;
    logic [SIZE_W-1:0]  scan_count       = '0;
    logic [INDEX_W-1:0] scan_index       = '0;
    logic               scan_clean       = 1'b1;
    logic               scan_found       = 1'b0;
    logic               scan_marker_done = 1'b0;

    t_erased_hit pending_hits[$];

    int fail_count    = 0;
    int cycle_count   = 0;
    int rx_hold_left  = 0;
    bit tx_idle_en    = 1'b1;
    bit rx_idle_en    = 1'b1;

    erased_block_bitmap_encoder_top u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .push            (push),
        .full            (full),
        .i_data_byte     (i_data_byte),
        .i_last_byte     (i_last_byte),
        .empty           (empty),
        .pop             (pop),
        .o_encoded_value (o_encoded_value),
        .o_value_bytes   (o_value_bytes),
        .o_last_of_run   (o_last_of_run)
    );

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // run guard
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("erased_block_bitmap_encoder_top: mismatch");
            $finish;
        end
    end

    task automatic note_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
        fail_count++;
        // keep the log short when something is badly off
        if (fail_count <= MAX_PRINTED)
            $display("ERROR %s: got 0x%0h want 0x%0h (cycle %0d)", what, got, want,
                     cycle_count);
    endtask

    // expected results of one accepted byte
    task automatic predict_byte(input logic [7:0] data, input logic last);
        t_erased_hit made [2];
        logic [SIZE_W:0] count;
        int n;
        n = 0;
        if (data != ERASED_BYTE)
            scan_clean = 1'b0;
        count = {1'b0, scan_count} + 1'b1;
        // a size of zero ends every byte's block, same as one
        if (count >= {1'b0, scan_size} || last) begin
            if (scan_clean) begin
                scan_found = 1'b1;
                if (scan_index < SMALL_INDEX_LIMIT) begin
                    made[n] = '{value: VALUE_W'(scan_index), nbytes: VB_SMALL, last: 1'b0};
                    n++;
                end else begin
                    if (!scan_marker_done) begin
                        made[n] = '{value: MARKER_VALUE, nbytes: VB_MARKER, last: 1'b0};
                        n++;
                        scan_marker_done = 1'b1;
                    end
                    made[n] = '{value: VALUE_W'(scan_index), nbytes: VB_LARGE, last: 1'b0};
                    n++;
                end
            end
            scan_index = scan_index + 1'b1;
            scan_count = '0;
            scan_clean = 1'b1;
        end else begin
            scan_count = count[SIZE_W-1:0];
        end
        if (last) begin
            // nothing erased in the region: marker alone closes it
            if (!scan_found) begin
                made[n] = '{value: MARKER_VALUE, nbytes: VB_MARKER, last: 1'b0};
                n++;
            end
            scan_count       = '0;
            scan_index       = '0;
            scan_clean       = 1'b1;
            scan_found       = 1'b0;
            scan_marker_done = 1'b0;
        end
        if (n > 0)
            made[n-1].last = 1'b1;
        for (int k = 0; k < n; k++)
            pending_hits.push_back(made[k]);
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_erased_hit want;
        if (i_rst_n && pop && !empty) begin
            if (pending_hits.size() == 0) begin
                note_mismatch("unexpected result beat", o_encoded_value, 0);
            end else begin
                want = pending_hits.pop_front();
                if (o_encoded_value != want.value)
                    note_mismatch("encoded_value", o_encoded_value, want.value);
                if (o_value_bytes != want.nbytes)
                    note_mismatch("value_bytes", o_value_bytes, want.nbytes);
                if (o_last_of_run != want.last)
                    note_mismatch("last_of_run", o_last_of_run, want.last);
            end
        end
    end

    // receiver: random stall bursts, plus a long hold-off when asked
    initial begin : drain_proc
        int stall_left;
        stall_left = 0;
        pop <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (rx_hold_left > 0) begin
                pop <= 1'b0;
                rx_hold_left = rx_hold_left - 1;
            end else if (stall_left > 0) begin
                pop <= 1'b0;
                stall_left = stall_left - 1;
            end else if (rx_idle_en && $urandom_range(0, 5) == 0) begin
                pop <= 1'b0;
                stall_left = $urandom_range(0, 9);
            end else begin
                pop <= 1'b1;
            end
        end
    end

    // one byte beat; push stays high into the next call unless a gap is taken
    task automatic send_byte(input logic [7:0] data, input logic last);
        int gap;
        if (tx_idle_en && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 10);
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push        <= 1'b1;
        i_data_byte <= data;
        i_last_byte <= last;
        do @(posedge i_clk); while (full);
        predict_byte(data, last);
    endtask

    task automatic wait_drained();
        push <= 1'b0;
        while (pending_hits.size() != 0) @(posedge i_clk);
        // bytes that cause no result may still be in flight
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // setup then access; psel drops and the bus idles afterwards
    task automatic apb_access(input logic write, input logic [APB_DW-1:0] wdata,
                              output logic [APB_DW-1:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= write;
        paddr   <= ADDR_BLOCK_SIZE;
        pwdata  <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_block_size(input logic [SIZE_W-1:0] value);
        logic [APB_DW-1:0] readback;
        wait_drained();
        apb_access(1'b1, APB_DW'(value), readback);
        scan_size = value;
        apb_access(1'b0, '0, readback);
        if (readback != APB_DW'(value))
            note_mismatch("block_size readback", readback, APB_DW'(value));
    endtask

    // well-formed region: whole blocks are either erased or carry stray bytes
    task automatic send_region(input int len, input int clean_pct);
        int eff;
        int pos;
        logic clean;
        logic [7:0] data;
        eff   = (scan_size == 0) ? 1 : int'(scan_size);
        pos   = 0;
        clean = 1'b1;
        for (int k = 0; k < len; k++) begin
            if (pos == 0)
                clean = ($urandom_range(0, 99) < clean_pct);
            if (clean || $urandom_range(0, 1) == 0)
                data = ERASED_BYTE;
            else
                data = 8'($urandom_range(0, 255));
            send_byte(data, k == len - 1);
            pos = (pos + 1 == eff) ? 0 : pos + 1;
        end
    endtask

    task automatic test_reset_default();
        logic [APB_DW-1:0] readback;
        int k;
        apb_access(1'b0, '0, readback);
        if (readback != APB_DW'(BLOCK_SIZE_RESET))
            note_mismatch("block_size after reset", readback, APB_DW'(BLOCK_SIZE_RESET));
        // short erased region under the reset size: one small index
        for (k = 0; k < 6; k++) send_byte(ERASED_BYTE, k == 5);
        // nothing erased: end marker
        for (k = 0; k < 3; k++) send_byte(8'h00, k == 2);
    endtask

    task automatic test_directed();
        set_block_size(17'd1);
        send_byte(ERASED_BYTE, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFE, 1'b0);
        send_byte(8'h7F, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(ERASED_BYTE, 1'b1);
        // region with no erased block
        set_block_size(17'd3);
        send_byte(8'h00, 1'b0);
        send_byte(8'h01, 1'b0);
        send_byte(8'h02, 1'b1);
        // zero size behaves like one
        set_block_size(17'd0);
        send_byte(ERASED_BYTE, 1'b0);
        send_byte(ERASED_BYTE, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(ERASED_BYTE, 1'b1);
        // size drops below the open block's count
        set_block_size(17'd4);
        send_byte(ERASED_BYTE, 1'b0);
        send_byte(ERASED_BYTE, 1'b0);
        set_block_size(17'd2);
        send_byte(ERASED_BYTE, 1'b0);
        send_byte(8'h00, 1'b1);
    endtask

    task automatic test_large_index();
        int k;
        set_block_size(17'd1);
        // first erased block above the small range: marker and index together
        for (k = 0; k < 300; k++)
            send_byte((k == 280) ? ERASED_BYTE : 8'h00, k == 299);
        // small first, marker later, final byte itself a large erased block
        for (k = 0; k < 260; k++)
            send_byte((k == 0 || k == 256 || k == 257 || k == 259) ? ERASED_BYTE : 8'h5A,
                      k == 259);
        // marker and large index both from the last byte
        for (k = 0; k < 258; k++)
            send_byte((k == 257) ? ERASED_BYTE : 8'hA5, k == 257);
    endtask

    task automatic test_queue_backpressure();
        int k;
        set_block_size(17'd1);
        // receiver goes quiet while erased bytes keep coming
        rx_hold_left = 200;
        for (k = 0; k < 40; k++) send_byte(ERASED_BYTE, k == 39);
    endtask

    task automatic test_random_regions();
        logic [SIZE_W-1:0] sizes [9];
        int sent;
        int len;
        int eff;
        int p;
        sizes = '{17'd2, 17'd1, 17'd4, 17'd0, 17'd65536, 17'd3, 17'h1FFFF, 17'd9, 17'd1};
        for (p = 0; p < 9; p++) begin
            if (p == 8) begin
                // flat out from here on
                tx_idle_en = 1'b0;
                rx_idle_en = 1'b0;
                set_block_size(SIZE_W'($urandom_range(1, 24)));
            end else begin
                set_block_size(sizes[p]);
            end
            eff  = (scan_size == 0) ? 1 : int'(scan_size);
            sent = 0;
            if (p == 1) begin
                send_region(60, 25);
                sent = 60;
            end
            while (sent < 20) begin
                if ($urandom_range(0, 9) == 0) begin
                    // noise: stray byte, sometimes closing a region early
                    send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
                    sent++;
                end else begin
                    len = $urandom_range(1, (eff * 4 < 40) ? eff * 4 : 40);
                    send_region(len, 60);
                    sent += len;
                end
            end
        end
    endtask

    initial begin
        i_rst_n     <= 1'b0;
        psel        <= 1'b0;
        penable     <= 1'b0;
        pwrite      <= 1'b0;
        paddr       <= '0;
        pwdata      <= '0;
        push        <= 1'b0;
        i_data_byte <= '0;
        i_last_byte <= 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_default();
        test_directed();
        test_large_index();
        test_queue_backpressure();
        test_random_regions();

        wait_drained();
        if (fail_count == 0)
            $display("erased_block_bitmap_encoder_top: match");
        else
            $display("erased_block_bitmap_encoder_top: mismatch");
        $finish;
    end

endmodule

>>> sim.f
rtl/core/ebbe_pkg.sv
rtl/core/ebbe_front.sv
rtl/core/ebbe_queue.sv
rtl/core/ebbe_back.sv
rtl/core/erased_block_bitmap_encoder_top.sv
tb/tb_erased_block_bitmap_encoder_top.sv
